// ===== src/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types, codes and default sizes for the substring search block.
// ----------------------------------------------------------------------------
package kmp_pkg;

  // default sizes
  localparam int MAX_PATTERN_DEFAULT = 32;
  localparam int MAX_TEXT_DEFAULT    = 65536;

  // request kinds
  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_PATTERN = 2'd1;
  localparam logic [1:0] MODE_TEXT    = 2'd2;
  localparam logic [1:0] MODE_END     = 2'd3;

  // result codes
  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
  } kmp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] position;
  } kmp_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } kmp_state_t;

endpackage

// ===== src/kmp_ram.sv =====
// ----------------------------------------------------------------------------
// kmp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/kmp_substring_search_top.sv =====
// ----------------------------------------------------------------------------
// kmp_substring_search_top
// Knuth-Morris-Pratt first-match search over a byte stream.
// ----------------------------------------------------------------------------
// A clear request starts a job; pattern bytes follow, then text bytes, then an
// end-of-text request. At most one result is returned per job: found with the
// start position, not found, or too long. Pattern bytes and their failure links
// live in two synchronous RAMs. A clear, the first pattern byte, an end of text,
// an overflow, a pattern byte after the text has begun, a text byte against an
// empty pattern and any request ignored after an answer are handled when they
// are accepted, with no walk. Any other pattern or text byte starts a walk that
// follows k failure links, each compare step waiting for a RAM read. Over a
// stream k averages below one per byte. While a result waits to be taken,
// requests are still accepted and ignored; once a clear has been taken, the
// input stalls until the waiting result is taken.
// ----------------------------------------------------------------------------
module kmp_substring_search_top #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEFAULT,
  parameter int MAX_TEXT    = kmp_pkg::MAX_TEXT_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  kmp_pkg::kmp_in_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output kmp_pkg::kmp_out_t out_item
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int TW = $clog2(MAX_TEXT + 1);
  localparam int SW = (TW > LW) ? TW : LW;

  kmp_pkg::kmp_state_t state, state_next;

  logic [LW-1:0] pat_len;
  logic [LW-1:0] build_prefix;
  logic [LW-1:0] match_prefix;
  logic [TW-1:0] text_count;
  logic          answer_given;
  logic [LW-1:0] j_reg;
  logic [7:0]    byte_reg;
  logic          is_build;

  logic          accept;
  logic          live;
  logic          pat_ok, pat_over, txt_empty, txt_over, txt_ok, end_item;
  logic [7:0]    p_rdata;
  logic [IW-1:0] f_rdata;
  logic [LW-1:0] f_ext;
  logic          hit, walk_more;
  logic [LW-1:0] jn;
  logic [LW-1:0] start_j, j_sel, j_dec;
  logic          p_we, f_we;
  logic [IW-1:0] f_wdata;
  logic [SW-1:0] pos_diff;

  // request decode
  assign in_ready = (state == kmp_pkg::ST_IDLE) && (!out_valid || answer_given);
  assign accept   = in_valid && in_ready;
  assign live     = !answer_given;

  always_comb begin
    pat_ok    = 1'b0;
    pat_over  = 1'b0;
    txt_empty = 1'b0;
    txt_over  = 1'b0;
    txt_ok    = 1'b0;
    end_item  = 1'b0;
    case (in_item.mode)
      kmp_pkg::MODE_PATTERN: begin
        pat_ok   = live && (text_count == '0) && (pat_len < LW'(MAX_PATTERN));
        pat_over = live && (text_count == '0) && (pat_len >= LW'(MAX_PATTERN));
      end
      kmp_pkg::MODE_TEXT: begin
        txt_empty = live && (pat_len == '0);
        txt_over  = live && (pat_len != '0) && (text_count >= TW'(MAX_TEXT));
        txt_ok    = live && (pat_len != '0) && (text_count < TW'(MAX_TEXT));
      end
      kmp_pkg::MODE_END: begin
        end_item = live;
      end
      default: begin
      end
    endcase
  end

  // compare step on the returned pattern byte
  assign f_ext     = LW'(f_rdata);
  assign hit       = (p_rdata == byte_reg);
  assign walk_more = (j_reg != '0) && !hit;
  assign jn        = hit ? (j_reg + LW'(1)) : j_reg;
  assign pos_diff  = SW'(text_count) - SW'(pat_len);

  // read address: start prefix on accept, else the followed link
  assign start_j = (in_item.mode == kmp_pkg::MODE_PATTERN) ? build_prefix : match_prefix;
  assign j_sel   = (state == kmp_pkg::ST_IDLE) ? start_j : f_ext;
  assign j_dec   = j_sel - LW'(1);

  // next state and memory controls
  always_comb begin
    state_next = state;
    p_we       = 1'b0;
    f_we       = 1'b0;
    f_wdata    = '0;
    case (state)
      kmp_pkg::ST_IDLE: begin
        if (accept) begin
          p_we = pat_ok;
          if (pat_ok && (pat_len == '0)) begin
            f_we = 1'b1;
          end
          if ((pat_ok && (pat_len != '0)) || txt_ok) begin
            state_next = kmp_pkg::ST_WALK;
          end
        end
      end
      kmp_pkg::ST_WALK: begin
        if (!walk_more) begin
          state_next = kmp_pkg::ST_IDLE;
          f_we       = is_build;
          f_wdata    = jn[IW-1:0];
        end
      end
      default: begin
        state_next = kmp_pkg::ST_IDLE;
      end
    endcase
  end

  // pattern bytes
  kmp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PATTERN)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (pat_len[IW-1:0]),
    .wdata (in_item.data),
    .raddr (j_sel[IW-1:0]),
    .rdata (p_rdata)
  );

  // failure links
  kmp_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_PATTERN)
  ) u_link_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (pat_len[IW-1:0]),
    .wdata (f_wdata),
    .raddr (j_dec[IW-1:0]),
    .rdata (f_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // job state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len      <= '0;
      build_prefix <= '0;
      match_prefix <= '0;
      text_count   <= '0;
      answer_given <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        byte_reg <= in_item.data;
        is_build <= (in_item.mode == kmp_pkg::MODE_PATTERN);
        if (in_item.mode == kmp_pkg::MODE_CLEAR) begin
          pat_len      <= '0;
          build_prefix <= '0;
          match_prefix <= '0;
          text_count   <= '0;
          answer_given <= 1'b0;
        end
        if (pat_ok) begin
          if (pat_len == '0) begin
            build_prefix <= '0;
            pat_len      <= LW'(1);
          end else begin
            j_reg <= build_prefix;
          end
        end
        if (txt_ok) begin
          text_count <= text_count + TW'(1);
          j_reg      <= match_prefix;
        end
        if (pat_over || txt_over) begin
          out_valid             <= 1'b1;
          answer_given          <= 1'b1;
          out_item.status       <= kmp_pkg::STATUS_TOO_LONG;
          out_item.position     <= '0;
        end
        if (txt_empty) begin
          out_valid             <= 1'b1;
          answer_given          <= 1'b1;
          out_item.status       <= kmp_pkg::STATUS_FOUND;
          out_item.position     <= '0;
        end
        if (end_item) begin
          out_valid         <= 1'b1;
          answer_given      <= 1'b1;
          out_item.status   <= (pat_len == '0) ? kmp_pkg::STATUS_FOUND
                                               : kmp_pkg::STATUS_NOT_FOUND;
          out_item.position <= '0;
        end
      end
      if (state == kmp_pkg::ST_WALK) begin
        if (walk_more) begin
          j_reg <= f_ext;
        end else if (is_build) begin
          build_prefix <= jn;
          pat_len      <= pat_len + LW'(1);
        end else begin
          match_prefix <= jn;
          if (jn == pat_len) begin
            out_valid         <= 1'b1;
            answer_given      <= 1'b1;
            out_item.status   <= kmp_pkg::STATUS_FOUND;
            out_item.position <= 16'(pos_diff);
          end
        end
      end
    end
  end

  // checks
  a_walk_below_len: assert property (@(posedge clk) disable iff (rst)
    (state == kmp_pkg::ST_WALK) |-> (j_reg < pat_len))
    else $error("walk prefix not below pattern length");

  a_build_below_len: assert property (@(posedge clk) disable iff (rst)
    (pat_len != '0) |-> (build_prefix < pat_len))
    else $error("build prefix not below pattern length");

  a_match_below_len: assert property (@(posedge clk) disable iff (rst)
    (!answer_given && (pat_len != '0)) |-> (match_prefix < pat_len))
    else $error("match prefix reached length without an answer");

  a_result_marks_answer: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> answer_given)
    else $error("result raised without marking the job answered");

  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == kmp_pkg::ST_WALK) |-> !in_ready)
    else $error("request taken during a link walk");

endmodule
